FILE: rtl/mskf_pkg.sv
// Shared types, constants and codes for the motor state Kalman filter.
// Used by the divider, datapath, controller and top level; no dependencies.
package mskf_pkg;

  localparam int STATE_COUNT = 4;
  localparam int FRAC_BITS   = 16;
  localparam int COEF_FRAC   = 14;
  localparam int MAT_SIZE    = STATE_COUNT * STATE_COUNT;

  // Divider works on |P| shifted up by the fraction bits
  localparam int DIV_W     = 32 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] NEG_ONE = -ONE;

  // Covariance diagonal after reset: 100.0, saturated to 32 bits
  localparam logic signed [63:0] P_DIAG_WIDE = 64'sd100 <<< FRAC_BITS;
  localparam logic signed [31:0] P_DIAG =
    (P_DIAG_WIDE > 64'sd2147483647) ? 32'sh7fff_ffff : P_DIAG_WIDE[31:0];

  // Register reset values
  localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_4000;
  localparam logic [63:0] ROW1_RST = 64'h0000_0000_4000_0000;
  localparam logic [63:0] ROW2_RST = 64'h0000_4000_0000_0000;
  localparam logic [63:0] ROW3_RST = 64'h4000_0000_0000_0000;
  localparam logic [30:0] R_RST    = 31'd65536;

  // Register indexes
  localparam logic [2:0] REG_ROW0 = 3'd0;
  localparam logic [2:0] REG_ROW1 = 3'd1;
  localparam logic [2:0] REG_ROW2 = 3'd2;
  localparam logic [2:0] REG_ROW3 = 3'd3;
  localparam logic [2:0] REG_BCOL = 3'd4;
  localparam logic [2:0] REG_QN   = 3'd5;
  localparam logic [2:0] REG_RN   = 3'd6;

  // Item commands
  localparam logic [1:0] CMD_PRED_UPD = 2'd0;
  localparam logic [1:0] CMD_PRED     = 2'd1;
  localparam logic [1:0] CMD_UPD      = 2'd2;
  localparam logic [1:0] CMD_RESET    = 2'd3;

  // Multiplier operand pairs
  localparam logic [3:0] TK_AX  = 4'd0;   // A[i][n] * X[n]
  localparam logic [3:0] TK_BU  = 4'd1;   // B[i] * u
  localparam logic [3:0] TK_AP  = 4'd2;   // A[i][n] * P[n][j]
  localparam logic [3:0] TK_TA  = 4'd3;   // T[i][n] * A[j][n]
  localparam logic [3:0] TK_P00 = 4'd4;   // P[0][0] * 1
  localparam logic [3:0] TK_R1  = 4'd5;   // R * 1
  localparam logic [3:0] TK_Z   = 4'd6;   // z * 1
  localparam logic [3:0] TK_X0N = 4'd7;   // X[0] * -1
  localparam logic [3:0] TK_KE  = 4'd8;   // K[i] * e
  localparam logic [3:0] TK_XI  = 4'd9;   // X[i] * 1
  localparam logic [3:0] TK_KN  = 4'd10;  // K[i] * -1
  localparam logic [3:0] TK_ONE = 4'd11;  // 1 * 1
  localparam logic [3:0] TK_MP  = 4'd12;  // M[i][n] * P[n][j]
  localparam logic [3:0] TK_KK  = 4'd13;  // K[i] * K[j]
  localparam logic [3:0] TK_PR  = 4'd14;  // P[i][j] * R
  localparam logic [3:0] TK_TM  = 4'd15;  // T[i][n] * M[j][n]

  // Accumulator destinations
  localparam logic [3:0] D_NX = 4'd0;   // predicted state, round by coef bits
  localparam logic [3:0] D_T  = 4'd1;   // temp matrix, round by coef bits for A*P terms only
  localparam logic [3:0] D_PQ = 4'd2;   // covariance plus Q, round by coef bits
  localparam logic [3:0] D_S  = 4'd3;   // innovation variance
  localparam logic [3:0] D_E  = 4'd4;   // innovation
  localparam logic [3:0] D_X  = 4'd5;   // corrected state
  localparam logic [3:0] D_MC = 4'd6;   // first column of I-KC
  localparam logic [3:0] D_P  = 4'd7;   // covariance, plain
  localparam logic [3:0] D_PP = 4'd8;   // covariance plus old entry

  typedef struct packed {
    logic            mac_valid;
    logic [3:0]      kind;
    logic [1:0]      i;
    logic [1:0]      j;
    logic [1:0]      n;
    logic            first;
    logic            last;
    logic [3:0]      dest;
    logic            ld_in;
    logic            cpy;
    logic            clr;
    logic            div_start;
    logic            set_skip;
    logic            ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       div_done;
    logic       s_nonpos;
    logic [1:0] cmd;
  } dp_stat_t;

  typedef struct packed {
    logic [3:0][63:0] a_rows;
    logic [63:0]      b_col;
    logic [30:0]      q_noise;
    logic [30:0]      r_noise;
  } cfg_t;

endpackage

FILE: rtl/mskf_div.sv
// Restoring divider for the Kalman gain: sat32((p << FRAC_BITS) / s).
// One quotient bit per cycle; depends on mskf_pkg.
module mskf_div import mskf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic        [31:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic                 running;
  logic                 neg;
  logic [31:0]          rem;
  logic [31:0]          dsr;
  logic [DIV_W-1:0]     q;
  logic [DIV_CNT_W-1:0] cnt;
  logic [32:0]          trial;
  logic                 ge;
  logic [31:0]          mag;

  assign mag   = dividend[31] ? 32'(-dividend) : 32'(dividend);
  assign trial = {rem, q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  // Shift the dividend out of q while quotient bits shift in
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      neg     <= dividend[31];
      q       <= {mag, {FRAC_BITS{1'b0}}};
      rem     <= '0;
      dsr     <= divisor;
      cnt     <= '0;
    end else if (running) begin
      rem  <= ge ? 32'(trial - {1'b0, dsr}) : trial[31:0];
      q    <= {q[DIV_W-2:0], ge};
      cnt  <= cnt + 1'b1;
      done <= (cnt == DIV_CNT_W'(DIV_W - 1));
      if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
        running <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Apply sign and saturate the magnitude
  always_comb begin
    if (neg) begin
      if (q > {{(DIV_W-32){1'b0}}, 32'h8000_0000}) quotient = 32'sh8000_0000;
      else quotient = -$signed(q[31:0]);
    end else begin
      if (q > {{(DIV_W-32){1'b0}}, 32'h7fff_ffff}) quotient = 32'sh7fff_ffff;
      else quotient = $signed(q[31:0]);
    end
  end

endmodule

FILE: rtl/mskf_dp.sv
// Datapath: filter state, temporaries, shared multiply-accumulate pipeline
// and gain divider. Driven by mskf_ctrl; depends on mskf_pkg and mskf_div.
module mskf_dp import mskf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  cfg_t               cfg,
  input  logic        [1:0]  in_command,
  input  logic signed [31:0] in_voltage,
  input  logic signed [31:0] in_position,
  output logic signed [31:0] out_x [STATE_COUNT],
  output logic               out_skip
);

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       rnd;
    logic [3:0] dest;
    logic [1:0] i;
    logic [1:0] j;
  } pipe_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic signed [31:0] x_vec  [STATE_COUNT];
  logic signed [31:0] nx_vec [STATE_COUNT];
  logic signed [31:0] k_vec  [STATE_COUNT];
  logic signed [31:0] kb_vec [STATE_COUNT];
  logic signed [31:0] mc_vec [STATE_COUNT];
  logic signed [31:0] p_mat  [MAT_SIZE];
  logic signed [31:0] t_mat  [MAT_SIZE];
  logic signed [31:0] s_reg, e_reg, u_reg, z_reg;
  logic        [1:0]  cmd_reg;
  logic               skip;

  pipe_t              p1, p2, p3;
  logic signed [63:0] prod, term, acc;

  logic        [1:0]  row_sel, x_addr, mc_addr, m_row;
  logic        [3:0]  p_addr;
  logic signed [31:0] coef, bcoef, x_rd, p_rd, t_rd, mc_rd, m_val;
  logic signed [31:0] op_a, op_b;
  logic        [15:0] coef_raw, bcoef_raw;
  logic               rnd16, fin_valid, r14;
  logic signed [63:0] fin_v, addend;
  logic signed [31:0] fin_s1, fin_res;

  logic               div_done;
  logic signed [31:0] div_q;
  logic        [1:0]  div_idx;

  // Operand read ports
  assign fin_valid = p3.valid && p3.last;
  assign row_sel   = (cmd.kind == TK_TA) ? cmd.j : cmd.i;
  assign coef_raw  = cfg.a_rows[row_sel][16*cmd.n +: 16];
  assign bcoef_raw = cfg.b_col[16*cmd.i +: 16];
  assign coef      = 32'(signed'(coef_raw));
  assign bcoef     = 32'(signed'(bcoef_raw));
  assign x_addr    = (cmd.kind == TK_AX) ? cmd.n : (cmd.kind == TK_XI) ? cmd.i : 2'd0;
  assign x_rd      = x_vec[x_addr];
  assign t_rd      = t_mat[{cmd.i, cmd.n}];
  assign m_row     = (cmd.kind == TK_MP) ? cmd.i : cmd.j;
  assign mc_addr   = m_row;
  assign mc_rd     = mc_vec[mc_addr];
  assign m_val     = (cmd.n == 2'd0) ? mc_rd : ((m_row == cmd.n) ? ONE : 32'sd0);

  always_comb begin
    if (fin_valid && p3.dest == D_PP) p_addr = {p3.i, p3.j};
    else if (cmd.kind == TK_AP || cmd.kind == TK_MP) p_addr = {cmd.n, cmd.j};
    else if (cmd.kind == TK_PR) p_addr = {cmd.i, cmd.j};
    else p_addr = {cmd.i, 2'd0};
  end
  assign p_rd = p_mat[p_addr];

  // Select the operand pair for this term
  always_comb begin
    rnd16 = 1'b1;
    unique case (cmd.kind)
      TK_AX:   begin op_a = coef;  op_b = x_rd;  rnd16 = 1'b0; end
      TK_BU:   begin op_a = bcoef; op_b = u_reg; rnd16 = 1'b0; end
      TK_AP:   begin op_a = coef;  op_b = p_rd;  rnd16 = 1'b0; end
      TK_TA:   begin op_a = t_rd;  op_b = coef;  rnd16 = 1'b0; end
      TK_P00:  begin op_a = p_rd;  op_b = ONE; end
      TK_R1:   begin op_a = $signed({1'b0, cfg.r_noise}); op_b = ONE; end
      TK_Z:    begin op_a = z_reg; op_b = ONE; end
      TK_X0N:  begin op_a = x_rd;  op_b = NEG_ONE; end
      TK_KE:   begin op_a = k_vec[cmd.i]; op_b = e_reg; end
      TK_XI:   begin op_a = x_rd;  op_b = ONE; end
      TK_KN:   begin op_a = k_vec[cmd.i]; op_b = NEG_ONE; end
      TK_ONE:  begin op_a = ONE;   op_b = ONE; end
      TK_MP:   begin op_a = m_val; op_b = p_rd; end
      TK_KK:   begin op_a = k_vec[cmd.i]; op_b = kb_vec[cmd.j]; end
      TK_PR:   begin op_a = p_rd;  op_b = $signed({1'b0, cfg.r_noise}); end
      default: begin op_a = t_rd;  op_b = m_val; end
    endcase
  end

  // Multiply, round, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      p1.valid <= 1'b0;
      p2.valid <= 1'b0;
      p3.valid <= 1'b0;
    end else begin
      p1 <= '{valid: cmd.mac_valid, first: cmd.first, last: cmd.last, rnd: rnd16,
              dest: cmd.dest, i: cmd.i, j: cmd.j};
      p2 <= p1;
      p3 <= p2;
    end
    prod <= op_a * op_b;
    term <= p1.rnd ? ((prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS) : prod;
    if (p2.valid) acc <= (p2.first ? 64'sd0 : acc) + term;
  end

  // Finish a sum: coefficient rounding for coefficient products, saturate,
  // optional addend
  always_comb begin
    r14    = !p3.rnd;
    fin_v  = r14 ? ((acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC) : acc;
    fin_s1 = sat32(fin_v);
    if (p3.dest == D_PQ && p3.i == 2'd1 && p3.j == 2'd1)
      addend = 64'(signed'({1'b0, cfg.q_noise}));
    else if (p3.dest == D_PP) addend = 64'(p_rd);
    else addend = 64'sd0;
    fin_res = sat32(64'(fin_s1) + addend);
  end

  mskf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (p_rd),
    .divisor  (s_reg),
    .done     (div_done),
    .quotient (div_q)
  );

  // Filter state and result writeback
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      for (int e = 0; e < MAT_SIZE; e++)
        p_mat[e] <= ((e / STATE_COUNT) == (e % STATE_COUNT)) ? P_DIAG : 32'sd0;
      for (int e = 0; e < STATE_COUNT; e++) x_vec[e] <= 32'sd0;
    end else if (cmd.cpy) begin
      for (int e = 0; e < STATE_COUNT; e++) x_vec[e] <= nx_vec[e];
    end else if (fin_valid) begin
      unique case (p3.dest)
        D_NX:    nx_vec[p3.i] <= fin_res;
        D_T:     t_mat[{p3.i, p3.j}] <= fin_res;
        D_S:     s_reg <= fin_res;
        D_E:     e_reg <= fin_res;
        D_X:     x_vec[p3.i] <= fin_res;
        D_MC:    mc_vec[p3.i] <= fin_res;
        default: p_mat[{p3.i, p3.j}] <= fin_res;
      endcase
    end
    if (cmd.div_start) div_idx <= cmd.i;
    if (div_done) begin
      k_vec[div_idx]  <= div_q;
      kb_vec[div_idx] <= div_q;
    end
  end

  // Input latch, skip flag and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      skip <= 1'b0;
    end else if (cmd.ld_in) begin
      skip <= 1'b0;
    end else if (cmd.set_skip) begin
      skip <= 1'b1;
    end
    if (cmd.ld_in) begin
      cmd_reg <= in_command;
      u_reg   <= in_voltage;
      z_reg   <= in_position;
    end
    if (cmd.ld_out) begin
      for (int e = 0; e < STATE_COUNT; e++) out_x[e] <= x_vec[e];
      out_skip <= skip;
    end
  end

  assign stat.busy     = p1.valid || p2.valid || p3.valid;
  assign stat.div_done = div_done;
  assign stat.s_nonpos = (s_reg <= 32'sd0);
  assign stat.cmd      = cmd_reg;

endmodule

FILE: rtl/mskf_ctrl.sv
// Controller: sequences predict and update phases through the datapath
// and runs both stream handshakes. Depends on mskf_pkg.
module mskf_ctrl import mskf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DISP  = 5'd1;
  localparam logic [4:0] ST_CLR   = 5'd2;
  localparam logic [4:0] ST_PX    = 5'd3;
  localparam logic [4:0] ST_CPY   = 5'd4;
  localparam logic [4:0] ST_AP    = 5'd5;
  localparam logic [4:0] ST_TA    = 5'd6;
  localparam logic [4:0] ST_SE    = 5'd7;
  localparam logic [4:0] ST_CHK   = 5'd8;
  localparam logic [4:0] ST_DIV   = 5'd9;
  localparam logic [4:0] ST_DIVW  = 5'd10;
  localparam logic [4:0] ST_XU    = 5'd11;
  localparam logic [4:0] ST_MC    = 5'd12;
  localparam logic [4:0] ST_MP    = 5'd13;
  localparam logic [4:0] ST_KK    = 5'd14;
  localparam logic [4:0] ST_PR    = 5'd15;
  localparam logic [4:0] ST_TM    = 5'd16;
  localparam logic [4:0] ST_DRAIN = 5'd17;
  localparam logic [4:0] ST_DONE  = 5'd18;

  logic [4:0] state, ret, after;
  logic [1:0] ci, cj, imax;
  logic [2:0] ct, nterm;
  logic       use_j, issue, loop_end;

  // Decode the current state into datapath commands
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    nterm    = 3'd1;
    use_j    = 1'b0;
    imax     = 2'd3;
    issue    = 1'b0;
    after    = ST_DONE;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.ld_in  = s_tvalid;
      end
      ST_CLR: cmd.clr = 1'b1;
      ST_CPY: cmd.cpy = 1'b1;
      ST_CHK: cmd.set_skip = stat.s_nonpos;
      ST_DIV: cmd.div_start = 1'b1;
      ST_DONE: cmd.ld_out = !m_tvalid || m_tready;
      ST_PX: begin
        issue = 1'b1; nterm = 3'd5; after = ST_CPY;
        cmd.kind = (ct == 3'd4) ? TK_BU : TK_AX;
        cmd.dest = D_NX;
      end
      ST_AP: begin
        issue = 1'b1; nterm = 3'd4; use_j = 1'b1; after = ST_TA;
        cmd.kind = TK_AP; cmd.dest = D_T;
      end
      ST_TA: begin
        issue = 1'b1; nterm = 3'd4; use_j = 1'b1;
        after = (stat.cmd == CMD_PRED_UPD) ? ST_SE : ST_DONE;
        cmd.kind = TK_TA; cmd.dest = D_PQ;
      end
      ST_SE: begin
        issue = 1'b1; nterm = 3'd2; imax = 2'd1; after = ST_CHK;
        if (ci == 2'd0) begin
          cmd.kind = (ct == 3'd0) ? TK_P00 : TK_R1;
          cmd.dest = D_S;
        end else begin
          cmd.kind = (ct == 3'd0) ? TK_Z : TK_X0N;
          cmd.dest = D_E;
        end
      end
      ST_XU: begin
        issue = 1'b1; nterm = 3'd2; after = ST_MC;
        cmd.kind = (ct == 3'd0) ? TK_KE : TK_XI;
        cmd.dest = D_X;
      end
      ST_MC: begin
        issue = 1'b1; nterm = (ci == 2'd0) ? 3'd2 : 3'd1; after = ST_MP;
        cmd.kind = (ct == 3'd0) ? TK_KN : TK_ONE;
        cmd.dest = D_MC;
      end
      ST_MP: begin
        issue = 1'b1; nterm = 3'd4; use_j = 1'b1; after = ST_KK;
        cmd.kind = TK_MP; cmd.dest = D_T;
      end
      ST_KK: begin
        issue = 1'b1; use_j = 1'b1; after = ST_PR;
        cmd.kind = TK_KK; cmd.dest = D_P;
      end
      ST_PR: begin
        issue = 1'b1; use_j = 1'b1; after = ST_TM;
        cmd.kind = TK_PR; cmd.dest = D_P;
      end
      ST_TM: begin
        issue = 1'b1; nterm = 3'd4; use_j = 1'b1; after = ST_DONE;
        cmd.kind = TK_TM; cmd.dest = D_PP;
      end
      default: ;
    endcase
    cmd.mac_valid = issue;
    cmd.i         = ci;
    cmd.j         = cj;
    cmd.n         = ct[1:0];
    cmd.first     = (ct == 3'd0);
    cmd.last      = (ct == 3'(nterm - 3'd1));
    loop_end      = cmd.last && (ci == imax) && (!use_j || cj == 2'd3);
  end

  // Advance state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ci       <= '0;
      cj       <= '0;
      ct       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.ld_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      if (issue) begin
        if (!cmd.last) begin
          ct <= ct + 3'd1;
        end else begin
          ct <= '0;
          if (loop_end) begin
            ci    <= '0;
            cj    <= '0;
            ret   <= after;
            state <= ST_DRAIN;
          end else if (use_j) begin
            cj <= cj + 2'd1;
            if (cj == 2'd3) ci <= ci + 2'd1;
          end else begin
            ci <= ci + 2'd1;
          end
        end
      end else begin
        priority case (state)
          ST_IDLE:  if (s_tvalid) state <= ST_DISP;
          ST_DISP: begin
            if (stat.cmd == CMD_RESET) state <= ST_CLR;
            else if (stat.cmd == CMD_UPD) state <= ST_SE;
            else state <= ST_PX;
          end
          ST_CLR:   state <= ST_DONE;
          ST_CPY:   state <= ST_AP;
          ST_CHK:   state <= stat.s_nonpos ? ST_DONE : ST_DIV;
          ST_DIV:   state <= ST_DIVW;
          ST_DIVW: begin
            if (stat.div_done) begin
              if (ci == 2'd3) begin
                ci    <= '0;
                state <= ST_XU;
              end else begin
                ci    <= ci + 2'd1;
                state <= ST_DIV;
              end
            end
          end
          ST_DRAIN: if (!stat.busy) state <= ret;
          ST_DONE:  if (cmd.ld_out) state <= ST_IDLE;
          default:  state <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

FILE: rtl/motor_state_kalman_filter_top.sv
// Top level of the four-state motor Kalman filter: configuration registers,
// controller and datapath. Depends on mskf_pkg, mskf_ctrl and mskf_dp.
//
// Usage:
//   Input words arrive on s_* (tuser carries the command, tdata the voltage
//   and the measured position). Each word yields exactly one result word on
//   m_* with the four state estimates and the update-skipped flag.
//   Configuration (A rows, B column, Q, R) is written over the APB port at
//   byte address 8*index while the filter is idle; pready is always high.
// Processing:
//   One word is processed at a time by a single shared 32x32 multiplier and
//   a one-bit-per-cycle gain divider; an update runs four gain divisions.
// Reset:
//   rst clears the state to zero, sets the covariance diagonal to 100.0 and
//   restores the register defaults; the reset command does the same for the
//   filter state only.
// Stall:
//   A finished result waits in the output register; the next input word is
//   still taken and its result is held until m_tready frees the register.
module motor_state_kalman_filter_top import mskf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] drive_voltage, [63:32] measured_position
  input  logic [63:0]  s_tdata,
  // [1:0] command
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] position, [63:32] speed, [95:64] torque, [127:96] current
  output logic [127:0] m_tdata,
  // [0] update_skipped
  output logic [0:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  cfg_t               cfg;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic signed [31:0] out_x [STATE_COUNT];
  logic               out_skip;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_rows[0] <= ROW0_RST;
      cfg.a_rows[1] <= ROW1_RST;
      cfg.a_rows[2] <= ROW2_RST;
      cfg.a_rows[3] <= ROW3_RST;
      cfg.b_col     <= '0;
      cfg.q_noise   <= '0;
      cfg.r_noise   <= R_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROW0: cfg.a_rows[0] <= pwdata;
        REG_ROW1: cfg.a_rows[1] <= pwdata;
        REG_ROW2: cfg.a_rows[2] <= pwdata;
        REG_ROW3: cfg.a_rows[3] <= pwdata;
        REG_BCOL: cfg.b_col     <= pwdata;
        REG_QN:   cfg.q_noise   <= pwdata[30:0];
        REG_RN:   cfg.r_noise   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_ROW0: prdata = cfg.a_rows[0];
      REG_ROW1: prdata = cfg.a_rows[1];
      REG_ROW2: prdata = cfg.a_rows[2];
      REG_ROW3: prdata = cfg.a_rows[3];
      REG_BCOL: prdata = cfg.b_col;
      REG_QN:   prdata = {33'd0, cfg.q_noise};
      REG_RN:   prdata = {33'd0, cfg.r_noise};
      default:  prdata = '0;
    endcase
  end

  mskf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mskf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg         (cfg),
    .in_command  (s_tuser),
    .in_voltage  (s_tdata[31:0]),
    .in_position (s_tdata[63:32]),
    .out_x       (out_x),
    .out_skip    (out_skip)
  );

  assign m_tdata = {out_x[3], out_x[2], out_x[1], out_x[0]};
  assign m_tuser = out_skip;

endmodule
